// ===== rtl/core/mbe_pkg.sv =====
// Shared widths, register indexes and reset values of the escape-time engine.
`default_nettype none

package mbe_pkg;

  localparam int PIX_W     = 10;
  localparam int CNT_W     = 16;
  localparam int STEP_W    = 63;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam int             GRID_SIZE = 1024;
  localparam logic [16:0]    GRID_LAST = 17'(GRID_SIZE - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_IM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd3;

  localparam logic [STEP_W-1:0] STEP_RESET     = 63'd5764607523034235;
  localparam logic [CNT_W-1:0]  MAX_ITER_RESET = 16'd1000;

endpackage

`default_nettype wire

// ===== rtl/core/mbe_cplx_sq.sv =====
// Shared 32x32 multiplier unit: exact squares and cross product of |z| over 12 passes.
`default_nettype none

module mbe_cplx_sq #(
  parameter int FIXED_WIDTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           go,
  input  wire logic [FIXED_WIDTH-1:0]         z_re,
  input  wire logic [FIXED_WIDTH-1:0]         z_im,
  output logic                                done,
  output logic [4*((FIXED_WIDTH+1)/2)-1:0]    p_rr,
  output logic [4*((FIXED_WIDTH+1)/2)-1:0]    p_ii,
  output logic [4*((FIXED_WIDTH+1)/2)-1:0]    p_ri
);

  localparam int W  = FIXED_WIDTH;
  localparam int H  = (W + 1) / 2;
  localparam int PW = 4 * H;
  localparam int NPP = 12;

  localparam logic [3:0] CNT_LAST = 4'(NPP - 1);

  localparam logic [1:0] PRD_RR = 2'd0;
  localparam logic [1:0] PRD_II = 2'd1;
  localparam logic [1:0] PRD_RI = 2'd2;

  logic            run_r;
  logic [3:0]      cnt_r;
  logic            pp_vld_r;
  logic            pp_last_r;
  logic            done_r;
  logic [2*H-1:0]  mag_re_r;
  logic [2*H-1:0]  mag_im_r;
  logic [2*H-1:0]  pp_r;
  logic [1:0]      pp_sel_r;
  logic [1:0]      pp_sh_r;
  logic [PW-1:0]   acc_rr_r;
  logic [PW-1:0]   acc_ii_r;
  logic [PW-1:0]   acc_ri_r;

  logic [W-1:0]    mag_re;
  logic [W-1:0]    mag_im;
  logic [2*H-1:0]  a_src;
  logic [2*H-1:0]  b_src;
  logic [H-1:0]    a_half;
  logic [H-1:0]    b_half;
  logic [PW-1:0]   pp_ext;
  logic [PW-1:0]   pp_shifted;

  assign mag_re = z_re[W-1] ? W'(-z_re) : z_re;
  assign mag_im = z_im[W-1] ? W'(-z_im) : z_im;

  always_comb begin
    a_src = (cnt_r[3:2] == PRD_II) ? mag_im_r : mag_re_r;
    b_src = (cnt_r[3:2] == PRD_RR) ? mag_re_r : mag_im_r;
    a_half = cnt_r[1] ? a_src[2*H-1:H] : a_src[H-1:0];
    b_half = cnt_r[0] ? b_src[2*H-1:H] : b_src[H-1:0];
  end

  always_comb begin
    pp_ext = PW'(pp_r);
    case (pp_sh_r)
      2'd0:    pp_shifted = pp_ext;
      2'd1:    pp_shifted = pp_ext << H;
      2'd2:    pp_shifted = pp_ext << (2 * H);
      default: pp_shifted = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      cnt_r     <= '0;
      pp_vld_r  <= 1'b0;
      pp_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      done_r    <= pp_vld_r & pp_last_r;
      pp_vld_r  <= run_r;
      pp_last_r <= run_r && (cnt_r == CNT_LAST);
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CNT_LAST) begin
          run_r <= 1'b0;
        end
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      mag_re_r <= (2*H)'(mag_re);
      mag_im_r <= (2*H)'(mag_im);
      acc_rr_r <= '0;
      acc_ii_r <= '0;
      acc_ri_r <= '0;
    end else if (pp_vld_r) begin
      case (pp_sel_r)
        PRD_RR:  acc_rr_r <= acc_rr_r + pp_shifted;
        PRD_II:  acc_ii_r <= acc_ii_r + pp_shifted;
        PRD_RI:  acc_ri_r <= acc_ri_r + pp_shifted;
        default: acc_ri_r <= acc_ri_r;
      endcase
    end
    if (run_r) begin
      pp_r     <= (2*H)'(a_half) * (2*H)'(b_half);
      pp_sel_r <= cnt_r[3:2];
      pp_sh_r  <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    end
  end

  assign done = done_r;
  assign p_rr = acc_rr_r;
  assign p_ii = acc_ii_r;
  assign p_ri = acc_ri_r;

endmodule

`default_nettype wire

// ===== rtl/core/mandelbrot_escape_time_top.sv =====
// Top level of the Mandelbrot escape-time engine: config registers, sequencer, z update.
//
// Usage:
//   Configure corner_real, corner_imag, step and max_iterations through the cfg_ write port
//   while busy is low; reset loads corner 0, step about 0.005 and a limit of 1000.
//   An item (in_pixel_x, in_pixel_y) is taken at a clock edge with start high and busy low.
//   busy stays high until the result is ready; one result item then appears on
//   out_escape_count / out_in_set for exactly one cycle with out_valid high, in the first
//   cycle busy is low again, so a new start may be given in that same cycle.
//   Each iteration is 12 partial products through the one shared 32x32 multiplier plus
//   pipeline fill, drain and the z update.
//   The receiver cannot stall: out_valid is a one-cycle strobe.
//   Synchronous reset aborts any item in flight and returns the block to idle.
`default_nettype none

module mandelbrot_escape_time_top
  import mbe_pkg::*;
#(
  parameter int FIXED_WIDTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [PIX_W-1:0]     in_pixel_x,
  input  wire logic [PIX_W-1:0]     in_pixel_y,
  output logic                      out_valid,
  output logic [CNT_W-1:0]          out_escape_count,
  output logic                      out_in_set,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int W      = FIXED_WIDTH;
  localparam int FRAC   = W - 4;
  localparam int H      = (W + 1) / 2;
  localparam int PW     = 4 * H;
  localparam int PROD_W = PIX_W + STEP_W;
  localparam int CW     = PROD_W + 2;

  localparam logic [PW:0] ESC_THR = (PW+1)'(1) << (2 * W - 6);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CRD_R  = 6'b000010,
    ST_CRD_I  = 6'b000100,
    ST_SETUP  = 6'b001000,
    ST_MUL    = 6'b010000,
    ST_UPDATE = 6'b100000
  } state_t;

  function automatic logic [W-1:0] sat_fx(input logic signed [CW-1:0] v);
    logic [CW-W:0] hi;
    hi = v[CW-1:W-1];
    if (hi == '0 || hi == '1) begin
      return v[W-1:0];
    end else if (v[CW-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  function automatic logic [PIX_W-1:0] clamp_pix(input logic [PIX_W-1:0] p);
    if (17'(p) > GRID_LAST) begin
      return PIX_W'(GRID_LAST);
    end
    return p;
  endfunction

  state_t               state_r, state_nxt;
  logic                 sq_go_r;
  logic                 out_valid_r;
  logic [CNT_W-1:0]     out_escape_count_r;
  logic                 out_in_set_r;

  logic [CFG_W-1:0]     corner_re_r;
  logic [CFG_W-1:0]     corner_im_r;
  logic [STEP_W-1:0]    step_r;
  logic [CNT_W-1:0]     max_iter_r;

  logic [PIX_W-1:0]     px_r;
  logic [PIX_W-1:0]     py_r;
  logic [PROD_W-1:0]    prod_r;
  logic [W-1:0]         c_re_r;
  logic [W-1:0]         c_im_r;
  logic [W-1:0]         z_re_r;
  logic [W-1:0]         z_im_r;
  logic [CNT_W-1:0]     iter_r;

  logic                 sq_done;
  logic [PW-1:0]        p_rr;
  logic [PW-1:0]        p_ii;
  logic [PW-1:0]        p_ri;

  logic [PIX_W-1:0]     mul_pix;
  logic [PROD_W-1:0]    prod_nxt;
  logic [W-1:0]         cn_re;
  logic [W-1:0]         cn_im;
  logic signed [CW-1:0] crd_up_sum;
  logic signed [CW-1:0] crd_dn_sum;

  logic [PW:0]          esc_sum;
  logic                 esc_hit;
  logic                 finish;

  logic [W-1:0]         rr_u;
  logic [W-1:0]         ii_u;
  logic [W-1:0]         ri_q;
  logic                 ri_rem;
  logic                 ri_neg;
  logic signed [CW-1:0] ri_mag;
  logic signed [CW-1:0] ri_s;
  logic signed [CW-1:0] re_sum;
  logic signed [CW-1:0] im_sum;

  mbe_cplx_sq #(
    .FIXED_WIDTH (W)
  ) u_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (sq_go_r),
    .z_re  (z_re_r),
    .z_im  (z_im_r),
    .done  (sq_done),
    .p_rr  (p_rr),
    .p_ii  (p_ii),
    .p_ri  (p_ri)
  );

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_re_r <= '0;
      corner_im_r <= '0;
      step_r      <= STEP_RESET;
      max_iter_r  <= MAX_ITER_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CORNER_RE: corner_re_r <= cfg_wdata;
        CFG_CORNER_IM: corner_im_r <= cfg_wdata;
        CFG_STEP:      step_r      <= cfg_wdata[STEP_W-1:0];
        CFG_MAX_ITER:  max_iter_r  <= cfg_wdata[CNT_W-1:0];
        default:       max_iter_r  <= max_iter_r;
      endcase
    end
  end

  // pixel coordinate: corner +/- pixel * step, saturated
  assign mul_pix  = (state_r == ST_CRD_R) ? px_r : py_r;
  assign prod_nxt = PROD_W'(mul_pix) * PROD_W'(step_r);

  always_comb begin
    cn_re      = sat_fx(CW'($signed(corner_re_r)));
    cn_im      = sat_fx(CW'($signed(corner_im_r)));
    crd_up_sum = CW'($signed(cn_re)) + $signed(CW'(prod_r));
    crd_dn_sum = CW'($signed(cn_im)) - $signed(CW'(prod_r));
  end

  // escape test on the exact squares of the current z
  always_comb begin
    esc_sum = (PW+1)'(p_rr) + (PW+1)'(p_ii);
    esc_hit = (iter_r != '0) && (esc_sum > ESC_THR);
    finish  = esc_hit || (iter_r == max_iter_r);
  end

  // next z from the products, floor rounding, saturated
  always_comb begin
    rr_u   = p_rr[FRAC +: W];
    ii_u   = p_ii[FRAC +: W];
    ri_q   = p_ri[FRAC-1 +: W];
    ri_rem = |p_ri[FRAC-2:0];
    ri_neg = z_re_r[W-1] ^ z_im_r[W-1];
    ri_mag = $signed(CW'(ri_q)) + $signed(CW'(ri_rem & ri_neg));
    ri_s   = ri_neg ? -ri_mag : ri_mag;
    re_sum = $signed(CW'(rr_u)) - $signed(CW'(ii_u)) + CW'($signed(c_re_r));
    im_sum = ri_s + CW'($signed(c_im_r));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_CRD_R;
      ST_CRD_R:  state_nxt = ST_CRD_I;
      ST_CRD_I:  state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = ST_MUL;
      ST_MUL: begin
        if (sq_done) begin
          state_nxt = finish ? ST_IDLE : ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_MUL;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sq_go_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sq_go_r     <= (state_r == ST_SETUP) || (state_r == ST_UPDATE);
      out_valid_r <= (state_r == ST_MUL) && sq_done && finish;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_MUL) && sq_done && finish) begin
      out_escape_count_r <= esc_hit ? iter_r : '0;
      out_in_set_r       <= !esc_hit;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          px_r <= clamp_pix(in_pixel_x);
          py_r <= clamp_pix(in_pixel_y);
        end
      end
      ST_CRD_R: prod_r <= prod_nxt;
      ST_CRD_I: begin
        c_re_r <= sat_fx(crd_up_sum);
        prod_r <= prod_nxt;
      end
      ST_SETUP: begin
        c_im_r <= sat_fx(crd_dn_sum);
        z_re_r <= '0;
        z_im_r <= '0;
        iter_r <= '0;
      end
      ST_MUL: ;
      ST_UPDATE: begin
        z_re_r <= sat_fx(re_sum);
        z_im_r <= sat_fx(im_sum);
        iter_r <= iter_r + CNT_W'(1);
      end
      default: ;
    endcase
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_escape_count = out_escape_count_r;
  assign out_in_set       = out_in_set_r;

endmodule

`default_nettype wire

// ===== rtl/core/mbe_chk.sv =====
// Port-level checker for the escape-time engine, bound to the top level.
`default_nettype none

module mbe_chk
  import mbe_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             out_valid,
  input wire logic [CNT_W-1:0] out_escape_count,
  input wire logic             out_in_set
);

  // an accepted item always makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but busy not raised");

  // every completed item ends with exactly its result strobe
  a_fall_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy dropped without a result item");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result item shown while still busy");

  a_in_set_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_set |-> out_escape_count == '0)
    else $error("in-set result with non-zero count");

  a_escape_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_set |-> out_escape_count != '0)
    else $error("escaped result with zero count");

endmodule

bind mandelbrot_escape_time_top mbe_chk u_mbe_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_escape_count (out_escape_count),
  .out_in_set       (out_in_set)
);

`default_nettype wire
